// ===== src/labc_pkg.sv =====
package labc_pkg;

	// fraction bits of the task rate and miss rate averages
	localparam int FRAC_BITS = 16;

	// a 40-bit task count times 1000 needs 50 bits, then the fraction shift
	localparam int DVD_W = 50 + FRAC_BITS;
	// divisor: task count plus one
	localparam int DEN_W = 41;
	// multiply-accumulate width
	localparam int ACC_W = 50;

	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [16:0] ALPHA_NEW = 17'd19661;
	localparam logic [16:0] ALPHA_OLD = 17'd45875;
	localparam logic [31:0] HALF_Q16  = 32'd32768;
	localparam logic [31:0] ROUND_UP  = 32'd65535;
	localparam logic [15:0] FIRST_DT  = 16'd1000;
	localparam logic [15:0] MIN_DT    = 16'd100;

	typedef enum logic [1:0] {
		ACT_TASK  = 2'd0,
		ACT_MISS  = 2'd1,
		ACT_BYTES = 2'd2,
		ACT_TICK  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_ENABLE   = 3'd0,
		REG_QUEUE    = 3'd1,
		REG_MISS     = 3'd2,
		REG_WAL      = 3'd3,
		REG_RANGE    = 3'd4,
		REG_WEIGHTS  = 3'd5,
		REG_HYST     = 3'd6,
		REG_MAX_STEP = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MAC_NOP,
		MAC_CLR,
		MAC_ADD
	} mac_op_t;

	typedef struct packed {
		mac_op_t     op;
		logic [31:0] a;
		logic [16:0] b;
	} mac_req_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIV_TASK,
		S_DIV_MISS,
		S_DIV_ING,
		S_SM_NEW,
		S_SM_OLD,
		S_SM_RND,
		S_SM_WR,
		S_PR,
		S_W_Q,
		S_W_M,
		S_W_W,
		S_W_RND,
		S_W_WR,
		S_C_MUL,
		S_C_RND,
		S_C_WR,
		S_OUT
	} state_t;

endpackage

// ===== src/labc_div.sv =====
// restoring divider, one quotient bit per cycle, quotient saturated to 32 bits
module labc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  labc_pkg::div_req_t req,
	output labc_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(labc_pkg::DVD_W + 1);
	localparam int DW    = labc_pkg::DEN_W;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [labc_pkg::DVD_W-1:0] dvd_q;
	logic [31:0]      quo_q;
	logic             sat_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	// trial subtract of the next dividend bit
	always_comb begin
		trial = {rem_q, dvd_q[labc_pkg::DVD_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(labc_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[labc_pkg::DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			sat_q <= sat_q | quo_q[31];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = sat_q ? 32'hFFFF_FFFF : quo_q;

endmodule

// ===== src/labc_mac.sv =====
// shared 32x17 multiply-accumulate, result registered
module labc_mac (
	input  logic                           clk,
	input  labc_pkg::mac_req_t             req,
	output logic [labc_pkg::ACC_W-1:0]     acc
);

	logic [labc_pkg::ACC_W-1:0] acc_q;
	logic [labc_pkg::ACC_W-1:0] prod;

	assign prod = labc_pkg::ACC_W'(req.a) * labc_pkg::ACC_W'(req.b);

	always_ff @(posedge clk) begin
		case (req.op)
			labc_pkg::MAC_CLR: acc_q <= prod;
			labc_pkg::MAC_ADD: acc_q <= acc_q + prod;
			default: acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

// ===== src/load_adaptive_budget_controller_top.sv =====
// Event items (add tasks, one miss, add bytes) are taken one per cycle, back to back, while in S_IDLE.
// A tick holds s_axis_tready low from its transaction until the sequencer is idle: each of up
// to six divisions takes a start, a step per dividend bit and a done in the shared divider, and
// smoothing, weighting and budget mapping run through the shared multiplier.
// A disabled tick goes straight to S_OUT; a result not yet taken holds the sequencer in S_OUT.
// arst_n clears accumulators, averages and aggressiveness; budget resets to 10.
module load_adaptive_budget_controller_top (
	input  logic          clk,
	input  logic          arst_n,
	// configuration writes
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [47:0]   cfg_data,
	// input items
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [47:0]   s_axis_tdata,  // amount[31:0], elapsed_ms[47:32]
	input  logic [1:0]    s_axis_tuser,  // action[1:0]
	// results
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [135:0]  m_axis_tdata   // budget[15:0], aggressiveness[32:16],
	                                     // task_rate_avg[64:33], miss_rate_avg[96:65],
	                                     // ingest_rate_avg[128:97], zero[135:129]
);

	localparam int F  = labc_pkg::FRAC_BITS;
	localparam int AW = labc_pkg::ACC_W;

	// configuration registers
	logic        enable_q;
	logic [31:0] queue_tgt_q, miss_tgt_q, wal_tgt_q, range_q;
	logic [47:0] weights_q;
	logic [15:0] hyst_q;
	logic [16:0] max_step_q;

	// controller state
	logic [39:0] task_q;
	logic [31:0] miss_q;
	logic [47:0] byte_q;
	logic [31:0] avg_q [3];
	logic [31:0] rate_q [3];
	logic [16:0] pres_q [3];
	logic [16:0] aggr_q;
	logic [15:0] budget_q;
	logic        first_q;
	logic [15:0] dt_q;
	logic [1:0]  idx_q;
	logic        issued_q;

	labc_pkg::state_t state_q, state_d;

	logic          out_valid_q;
	logic [135:0]  out_data_q;

	labc_pkg::div_req_t div_req;
	labc_pkg::div_rsp_t div_rsp;
	labc_pkg::mac_req_t mac_req;
	logic [AW-1:0]      acc;

	logic [1:0]  act;
	logic [31:0] amount;
	logic [15:0] ms;
	logic        in_acc;

	assign act    = s_axis_tuser;
	assign amount = s_axis_tdata[31:0];
	assign ms     = s_axis_tdata[47:32];
	assign in_acc = s_axis_tvalid & s_axis_tready;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == labc_pkg::S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// saturating accumulator sums
	logic [40:0] task_sum;
	logic [32:0] miss_sum;
	logic [48:0] byte_sum;
	assign task_sum = {1'b0, task_q} + 41'(amount);
	assign miss_sum = {1'b0, miss_q} + 33'd1;
	assign byte_sum = {1'b0, byte_q} + 49'(amount);

	// dividends scaled by 1000 ms
	logic [49:0] task_k;
	logic [57:0] byte_k;
	assign task_k = 50'(task_q) * 50'd1000;
	assign byte_k = 58'(byte_q) * 58'd1000;

	// selected average and target for pressure
	logic [31:0] avg_sel, tgt_sel;
	logic        p_low, p_full;
	always_comb begin
		avg_sel = avg_q[idx_q];
		case (idx_q)
			2'd0:    tgt_sel = queue_tgt_q;
			2'd1:    tgt_sel = miss_tgt_q;
			default: tgt_sel = wal_tgt_q;
		endcase
		p_low  = avg_sel <= tgt_sel;
		p_full = {1'b0, avg_sel} >= {tgt_sel, 1'b0};
	end

	// budget range and aggressiveness limit
	logic [15:0] bmin, bmax, bspan, offs, cand, bdiff;
	logic        inv;
	logic [AW-17:0] a_raw;
	logic [16:0] a_cl, a_lim;
	always_comb begin
		bmin  = range_q[15:0];
		bmax  = range_q[31:16];
		inv   = bmax < bmin;
		bspan = inv ? (bmin - bmax) : (bmax - bmin);
		offs  = acc[31:16];
		cand  = inv ? (bmin - offs) : (bmin + offs);
		bdiff = (cand > budget_q) ? (cand - budget_q) : (budget_q - cand);
		a_raw = acc[AW-1:16];
		a_cl  = (a_raw > (AW-16)'(labc_pkg::ONE_Q16)) ? labc_pkg::ONE_Q16 : a_raw[16:0];
		if (a_cl > aggr_q && (a_cl - aggr_q) > max_step_q)
			a_lim = aggr_q + max_step_q;
		else if (a_cl < aggr_q && (aggr_q - a_cl) > max_step_q)
			a_lim = aggr_q - max_step_q;
		else
			a_lim = a_cl;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			labc_pkg::S_IDLE:
				if (in_acc && act == labc_pkg::ACT_TICK)
					state_d = enable_q ? labc_pkg::S_DIV_TASK : labc_pkg::S_OUT;
			labc_pkg::S_DIV_TASK: if (div_rsp.done) state_d = labc_pkg::S_DIV_MISS;
			labc_pkg::S_DIV_MISS:
				if (task_q == '0 || div_rsp.done) state_d = labc_pkg::S_DIV_ING;
			labc_pkg::S_DIV_ING: if (div_rsp.done) state_d = labc_pkg::S_SM_NEW;
			labc_pkg::S_SM_NEW: state_d = labc_pkg::S_SM_OLD;
			labc_pkg::S_SM_OLD: state_d = labc_pkg::S_SM_RND;
			labc_pkg::S_SM_RND: state_d = labc_pkg::S_SM_WR;
			labc_pkg::S_SM_WR:
				state_d = (idx_q == 2'd2) ? labc_pkg::S_PR : labc_pkg::S_SM_NEW;
			labc_pkg::S_PR:
				if ((p_low || p_full || div_rsp.done) && idx_q == 2'd2)
					state_d = labc_pkg::S_W_Q;
			labc_pkg::S_W_Q:   state_d = labc_pkg::S_W_M;
			labc_pkg::S_W_M:   state_d = labc_pkg::S_W_W;
			labc_pkg::S_W_W:   state_d = labc_pkg::S_W_RND;
			labc_pkg::S_W_RND: state_d = labc_pkg::S_W_WR;
			labc_pkg::S_W_WR:  state_d = labc_pkg::S_C_MUL;
			labc_pkg::S_C_MUL: state_d = labc_pkg::S_C_RND;
			labc_pkg::S_C_RND: state_d = labc_pkg::S_C_WR;
			labc_pkg::S_C_WR:  state_d = labc_pkg::S_OUT;
			labc_pkg::S_OUT:
				if (!out_valid_q || m_axis_tready) state_d = labc_pkg::S_IDLE;
			default: state_d = labc_pkg::S_IDLE;
		endcase
	end

	// requests to the shared units
	always_comb begin
		div_req = '0;
		mac_req = '0;
		unique case (state_q)
			labc_pkg::S_DIV_TASK: begin
				div_req.start    = !issued_q;
				div_req.dividend = {task_k, {F{1'b0}}};
				div_req.divisor  = labc_pkg::DEN_W'(dt_q);
			end
			labc_pkg::S_DIV_MISS: begin
				div_req.start    = !issued_q && task_q != '0;
				div_req.dividend = labc_pkg::DVD_W'({miss_q, {F{1'b0}}});
				div_req.divisor  = labc_pkg::DEN_W'(task_q) + 1'b1;
			end
			labc_pkg::S_DIV_ING: begin
				div_req.start    = !issued_q;
				div_req.dividend = labc_pkg::DVD_W'(byte_k);
				div_req.divisor  = labc_pkg::DEN_W'(dt_q);
			end
			labc_pkg::S_SM_NEW: begin
				mac_req.op = labc_pkg::MAC_CLR;
				mac_req.a  = rate_q[idx_q];
				mac_req.b  = labc_pkg::ALPHA_NEW;
			end
			labc_pkg::S_SM_OLD: begin
				mac_req.op = labc_pkg::MAC_ADD;
				mac_req.a  = avg_q[idx_q];
				mac_req.b  = labc_pkg::ALPHA_OLD;
			end
			labc_pkg::S_SM_RND, labc_pkg::S_W_RND: begin
				mac_req.op = labc_pkg::MAC_ADD;
				mac_req.a  = labc_pkg::HALF_Q16;
				mac_req.b  = 17'd1;
			end
			labc_pkg::S_PR: begin
				div_req.start    = !issued_q && !p_low && !p_full;
				div_req.dividend = labc_pkg::DVD_W'({avg_sel - tgt_sel, 16'b0});
				div_req.divisor  = labc_pkg::DEN_W'(tgt_sel);
			end
			labc_pkg::S_W_Q: begin
				mac_req.op = labc_pkg::MAC_CLR;
				mac_req.a  = 32'(weights_q[15:0]);
				mac_req.b  = pres_q[0];
			end
			labc_pkg::S_W_M: begin
				mac_req.op = labc_pkg::MAC_ADD;
				mac_req.a  = 32'(weights_q[31:16]);
				mac_req.b  = pres_q[1];
			end
			labc_pkg::S_W_W: begin
				mac_req.op = labc_pkg::MAC_ADD;
				mac_req.a  = 32'(weights_q[47:32]);
				mac_req.b  = pres_q[2];
			end
			labc_pkg::S_C_MUL: begin
				mac_req.op = labc_pkg::MAC_CLR;
				mac_req.a  = 32'(bspan);
				mac_req.b  = aggr_q;
			end
			labc_pkg::S_C_RND: begin
				mac_req.op = labc_pkg::MAC_ADD;
				mac_req.a  = inv ? labc_pkg::ROUND_UP : 32'd0;
				mac_req.b  = 17'd1;
			end
			default: begin
				div_req = '0;
				mac_req = '0;
			end
		endcase
	end

	labc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	labc_mac u_mac (
		.clk (clk),
		.req (mac_req),
		.acc (acc)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			queue_tgt_q <= 32'd6553600;
			miss_tgt_q  <= 32'd3277;
			wal_tgt_q   <= 32'd10485760;
			range_q     <= 32'd131072010;
			weights_q   <= 48'd28151792684237;
			hyst_q      <= 16'd20;
			max_step_q  <= 17'd13107;
		end else if (cfg_valid && cfg_ready) begin
			unique case (labc_pkg::reg_idx_t'(cfg_index))
				labc_pkg::REG_ENABLE:   enable_q    <= cfg_data[0];
				labc_pkg::REG_QUEUE:    queue_tgt_q <= cfg_data[31:0];
				labc_pkg::REG_MISS:     miss_tgt_q  <= cfg_data[31:0];
				labc_pkg::REG_WAL:      wal_tgt_q   <= cfg_data[31:0];
				labc_pkg::REG_RANGE:    range_q     <= cfg_data[31:0];
				labc_pkg::REG_WEIGHTS:  weights_q   <= cfg_data;
				labc_pkg::REG_HYST:     hyst_q      <= cfg_data[15:0];
				labc_pkg::REG_MAX_STEP: max_step_q  <= cfg_data[16:0];
				default: enable_q <= enable_q;
			endcase
		end
	end

	// controller state and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= labc_pkg::S_IDLE;
			task_q      <= '0;
			miss_q      <= '0;
			byte_q      <= '0;
			avg_q[0]    <= '0;
			avg_q[1]    <= '0;
			avg_q[2]    <= '0;
			aggr_q      <= '0;
			budget_q    <= 16'd10;
			first_q     <= 1'b1;
			idx_q       <= '0;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// result register: refilled in S_OUT, emptied when taken
			if (state_q == labc_pkg::S_OUT && (!out_valid_q || m_axis_tready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			if (div_rsp.done)
				issued_q <= 1'b0;
			else if (div_req.start)
				issued_q <= 1'b1;
			case (state_q)
				labc_pkg::S_IDLE:
					if (in_acc && enable_q) begin
						case (act)
							labc_pkg::ACT_TASK:
								task_q <= task_sum[40] ? '1 : task_sum[39:0];
							labc_pkg::ACT_MISS:
								miss_q <= miss_sum[32] ? '1 : miss_sum[31:0];
							labc_pkg::ACT_BYTES:
								byte_q <= byte_sum[48] ? '1 : byte_sum[47:0];
							default: begin
								first_q <= 1'b0;
								idx_q   <= '0;
							end
						endcase
					end
				labc_pkg::S_DIV_TASK: if (div_rsp.done) rate_q[0] <= div_rsp.quot;
				labc_pkg::S_DIV_MISS:
					if (task_q == '0) rate_q[1] <= '0;
					else if (div_rsp.done) rate_q[1] <= div_rsp.quot;
				labc_pkg::S_DIV_ING: if (div_rsp.done) rate_q[2] <= div_rsp.quot;
				labc_pkg::S_SM_WR: begin
					avg_q[idx_q] <= acc[47:16];
					idx_q        <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
				labc_pkg::S_PR:
					if (p_low || p_full || div_rsp.done) begin
						if (p_low)
							pres_q[idx_q] <= '0;
						else if (p_full)
							pres_q[idx_q] <= labc_pkg::ONE_Q16;
						else
							pres_q[idx_q] <= div_rsp.quot[16:0];
						idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					end
				labc_pkg::S_W_WR: aggr_q <= a_lim;
				labc_pkg::S_C_WR: begin
					if (bdiff >= hyst_q)
						budget_q <= cand;
					task_q <= '0;
					miss_q <= '0;
					byte_q <= '0;
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// time base, taken with the tick
	always_ff @(posedge clk) begin
		if (state_q == labc_pkg::S_IDLE && in_acc && act == labc_pkg::ACT_TICK)
			dt_q <= first_q ? labc_pkg::FIRST_DT : (ms < labc_pkg::MIN_DT ? labc_pkg::MIN_DT : ms);
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == labc_pkg::S_OUT && (!out_valid_q || m_axis_tready))
			out_data_q <= {7'b0, avg_q[2], avg_q[1], avg_q[0], aggr_q, budget_q};
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		aggr_q <= labc_pkg::ONE_Q16)
		else $error("aggressiveness above one");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == labc_pkg::S_IDLE && !(in_acc && act == labc_pkg::ACT_TICK))
		|=> state_q == labc_pkg::S_IDLE)
		else $error("sequencer left idle without a tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == labc_pkg::S_DIV_TASK || state_q == labc_pkg::S_DIV_MISS
			|| state_q == labc_pkg::S_DIV_ING || state_q == labc_pkg::S_PR))
		else $error("divider running outside a division step");

endmodule
